// File: src/wildcard_flow_table_lookup_assert.svh
// Assertion macros for the wildcard flow table.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef WILDCARD_FLOW_TABLE_LOOKUP_ASSERT_SVH
`define WILDCARD_FLOW_TABLE_LOOKUP_ASSERT_SVH

// condition holds in the same cycle
`define WFTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence holds in the cycle after the trigger
`define WFTL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

// File: src/wftl_pkg.sv
// Types and codes shared by the wildcard flow table.
// No dependencies.
package wftl_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_HIT   = 3'd2,
    ST_MISS  = 3'd3,
    ST_TICK  = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] in_port;
    logic [15:0] eth_type;
    logic [47:0] eth_src;
    logic [47:0] eth_dst;
    logic [18:0] vlan_tag;
    logic [7:0]  ip_proto;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [31:0] l4_ports;
    logic [10:0] mask;
    logic [15:0] idle;
    logic [15:0] port;
    logic [31:0] expiry;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic expired;
  } match_t;

endpackage

// File: src/wftl_match.sv
// Wildcard key compare and idle timeout check for one stored entry.
// Depends on wftl_pkg.
module wftl_match (
  input  wftl_pkg::entry_t entry_i,
  input  wftl_pkg::entry_t key_i,
  input  logic [31:0]      now_i,
  output wftl_pkg::match_t result_o
);
  import wftl_pkg::*;

  logic [10:0] eq;
  logic [31:0] delta;

  always_comb begin
    eq[0]  = entry_i.in_port == key_i.in_port;
    eq[1]  = entry_i.eth_type == key_i.eth_type;
    eq[2]  = entry_i.eth_src == key_i.eth_src;
    eq[3]  = entry_i.eth_dst == key_i.eth_dst;
    eq[4]  = entry_i.vlan_tag[18:3] == key_i.vlan_tag[18:3];
    eq[5]  = entry_i.vlan_tag[2:0] == key_i.vlan_tag[2:0];
    eq[6]  = entry_i.ip_proto == key_i.ip_proto;
    eq[7]  = entry_i.ip_src == key_i.ip_src;
    eq[8]  = entry_i.ip_dst == key_i.ip_dst;
    eq[9]  = entry_i.l4_ports[31:16] == key_i.l4_ports[31:16];
    eq[10] = entry_i.l4_ports[15:0] == key_i.l4_ports[15:0];
    delta  = now_i - entry_i.expiry;
    result_o.hit     = &(eq | entry_i.mask);
    result_o.expired = (entry_i.idle != 16'd0) && (delta != 32'd0) && !delta[31];
  end

endmodule

// File: src/wildcard_flow_table_lookup.sv
// Wildcard flow table: an add, lookup or tick item in, one result item out.
// Entries and list links sit in two synchronous memories with registered reads.
// Valid and ready on both channels; an item moves when both are high.
// Action add puts the key in the lowest free slot, scanning one slot per
// cycle; no free slot answers table full.
// Action lookup walks a singly linked list from the newest entry to the
// oldest, one entry per cycle after a read of the head; an empty table
// answers miss without a walk. Timed-out entries
// met before the hit are unlinked and freed on the way; a hit with a nonzero
// idle timeout gets its expiry pushed to now plus the timeout.
// Tick and unused actions go straight to the done state once the item is taken.
// One item is in work at a time; the list walk sets the lookup time, and the
// next item can be taken in the cycle after each result loads.
// A finished result waits in an output register while the next item is
// taken; a stalled receiver holds the block in its last step until the
// output register frees.
// Reset empties the table and clears the tick count; there is no clearing
// pass.
module wildcard_flow_table_lookup #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] in_port_i,
  input  logic [15:0] eth_type_i,
  input  logic [47:0] eth_src_i,
  input  logic [47:0] eth_dst_i,
  input  logic [18:0] vlan_tag_i,
  input  logic [7:0]  ip_proto_i,
  input  logic [31:0] ip_src_i,
  input  logic [31:0] ip_dst_i,
  input  logic [31:0] l4_ports_i,
  input  logic [10:0] wildcard_mask_i,
  input  logic [31:0] timeout_and_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [15:0] out_port_o
);
  import wftl_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic            nil;
    logic [IdxW-1:0] idx;
  } ptr_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_LK_RD, S_LK_EV, S_DONE
  } state_e;

  state_e                   state_q;
  entry_t                   key_q;
  logic [IdxW-1:0]          idx_q, cur_q;
  ptr_t                     prev_q, head_q;
  logic [31:0]              now_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  status_e                  res_status_q;
  logic [5:0]               res_slot_q;
  logic [15:0]              res_port_q;
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [5:0]               out_slot_q;
  logic [15:0]              out_port_q;

  entry_t entry_mem [TABLE_ENTRIES];
  ptr_t   next_mem  [TABLE_ENTRIES];
  entry_t rd_entry_q;
  ptr_t   rd_next_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            ent_we, nxt_we;
  logic [IdxW-1:0] ent_wa, nxt_wa;
  entry_t          ent_wd;
  ptr_t            nxt_wd;
  match_t          mres;
  entry_t          in_key;
  logic            out_free;

  wftl_match u_match (
    .entry_i (rd_entry_q),
    .key_i   (key_q),
    .now_i   (now_q),
    .result_o(mres)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign out_port_o  = out_port_q;

  always_comb begin
    in_key.in_port  = in_port_i;
    in_key.eth_type = eth_type_i;
    in_key.eth_src  = eth_src_i;
    in_key.eth_dst  = eth_dst_i;
    in_key.vlan_tag = vlan_tag_i;
    in_key.ip_proto = ip_proto_i;
    in_key.ip_src   = ip_src_i;
    in_key.ip_dst   = ip_dst_i;
    in_key.l4_ports = l4_ports_i;
    in_key.mask     = wildcard_mask_i;
    in_key.idle     = timeout_and_port_i[31:16];
    in_key.port     = timeout_and_port_i[15:0];
    in_key.expiry   = now_q + {16'd0, timeout_and_port_i[31:16]};
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    ent_we  = 1'b0;
    ent_wa  = cur_q;
    ent_wd  = rd_entry_q;
    nxt_we  = 1'b0;
    nxt_wa  = prev_q.idx;
    nxt_wd  = rd_next_q;
    unique case (state_q)
      S_ADD: begin
        ent_wa = idx_q;
        ent_wd = key_q;
        nxt_wa = idx_q;
        nxt_wd = head_q;
        if (!valid_q[idx_q]) begin
          ent_we = 1'b1;
          nxt_we = 1'b1;
        end
      end
      S_LK_RD: rd_en = 1'b1;
      S_LK_EV: begin
        rd_en   = 1'b1;
        rd_addr = rd_next_q.idx;
        if (mres.expired) begin
          nxt_we = !prev_q.nil;
        end else if (mres.hit) begin
          ent_we = 1'b1;
          if (rd_entry_q.idle != 16'd0) begin
            ent_wd.expiry = now_q + {16'd0, rd_entry_q.idle};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_wa] <= ent_wd;
    end
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (rd_en) begin
      rd_entry_q <= entry_mem[rd_addr];
      rd_next_q  <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      key_q <= in_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cur_q        <= '0;
      prev_q       <= '{nil: 1'b1, idx: '0};
      head_q       <= '{nil: 1'b1, idx: '0};
      now_q        <= '0;
      valid_q      <= '0;
      res_status_q <= ST_MISS;
      res_slot_q   <= '0;
      res_port_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_MISS;
      out_slot_q   <= '0;
      out_port_q   <= '0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_slot_q <= '0;
            res_port_q <= '0;
            case (action_e'(action_i))
              ACT_ADD: begin
                idx_q   <= '0;
                state_q <= S_ADD;
              end
              ACT_LOOKUP: begin
                prev_q <= '{nil: 1'b1, idx: '0};
                cur_q  <= head_q.idx;
                if (head_q.nil) begin
                  res_status_q <= ST_MISS;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_LK_RD;
                end
              end
              ACT_TICK: begin
                now_q        <= now_q + 32'd1;
                res_status_q <= ST_TICK;
                state_q      <= S_DONE;
              end
              default: begin
                res_status_q <= ST_MISS;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            head_q         <= '{nil: 1'b0, idx: idx_q};
            res_status_q   <= ST_ADDED;
            res_slot_q     <= 6'(idx_q);
            state_q        <= S_DONE;
          end else if (idx_q == LastIdx) begin
            res_status_q <= ST_FULL;
            state_q      <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_LK_RD: state_q <= S_LK_EV;
        S_LK_EV: begin
          if (mres.expired) begin
            valid_q[cur_q] <= 1'b0;
            if (prev_q.nil) begin
              head_q <= rd_next_q;
            end
          end else if (mres.hit) begin
            res_status_q <= ST_HIT;
            res_slot_q   <= 6'(cur_q);
            res_port_q   <= rd_entry_q.port;
            state_q      <= S_DONE;
          end else begin
            prev_q <= '{nil: 1'b0, idx: cur_q};
          end
          if (mres.expired || !mres.hit) begin
            if (rd_next_q.nil) begin
              res_status_q <= ST_MISS;
              state_q      <= S_DONE;
            end else begin
              cur_q <= rd_next_q.idx;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_port_q   <= res_port_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "wildcard_flow_table_lookup_assert.svh"

  `WFTL_ASSERT(a_empty_list, (head_q.nil |-> (valid_q == '0)), "empty list with valid slots")
  `WFTL_ASSERT(a_walk_valid, ((state_q == S_LK_EV) |-> valid_q[cur_q]), "walk reached a free slot")
  `WFTL_ASSERT_NEXT(a_add_links, ((state_q == S_ADD) && !valid_q[idx_q]), (!head_q.nil && valid_q[head_q.idx]), "added slot not at list head")

endmodule
